@@ hdl/tftpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tftpsr_pkg
// shared types and constants of the lock-step block transfer sender
// ----------------------------------------------------------------------------
package tftpsr_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF   = 512;
  localparam int unsigned BLOCK_NUMBER_BITS_DEF = 16;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned ACK_W      = 16;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned BLK_OUT_W  = 16;
  localparam int unsigned RETRY_W    = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST     = 4'd5;
  localparam logic [SIZE_W-1:0]  FULL_BLOCK_SIZE_RST = 10'd512;

  // register indexes, selected by paddr[2]
  localparam logic REG_RETRY_LIMIT     = 1'b0;
  localparam logic REG_FULL_BLOCK_SIZE = 1'b1;

  // event codes
  localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ACK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAIL    = 3'd4;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_SEND        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WAIT        = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FETCH       = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DONE        = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ABORT_RETRY = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_ABORT_FAIL  = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FETCH = 3'b010,
    PH_WAIT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [RETRY_W-1:0] retry_limit;
    logic [SIZE_W-1:0]  full_block_size;
  } cfg_t;

endpackage

@@ hdl/tftpsr_cfg.sv @@
// ----------------------------------------------------------------------------
// tftpsr_cfg
// apb register file: retry limit and full block size
// ----------------------------------------------------------------------------
module tftpsr_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tftpsr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tftpsr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tftpsr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready,
  output tftpsr_pkg::cfg_t                    cfg_o
);
  import tftpsr_pkg::*;

  logic [RETRY_W-1:0] retry_limit_r;
  logic [SIZE_W-1:0]  full_block_size_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r     <= RETRY_LIMIT_RST;
      full_block_size_r <= FULL_BLOCK_SIZE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_RETRY_LIMIT:     retry_limit_r     <= pwdata[RETRY_W-1:0];
        REG_FULL_BLOCK_SIZE: full_block_size_r <= pwdata[SIZE_W-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_RETRY_LIMIT:     prdata[RETRY_W-1:0] = retry_limit_r;
      REG_FULL_BLOCK_SIZE: prdata[SIZE_W-1:0]  = full_block_size_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.retry_limit     = retry_limit_r;
  assign cfg_o.full_block_size = full_block_size_r;

endmodule

@@ hdl/tftp_sender_retry_engine.sv @@
// ----------------------------------------------------------------------------
// tftp_sender_retry_engine
// sending side of a lock-step block transfer with retry limit and
// duplicate acknowledgement suppression
// ----------------------------------------------------------------------------
// Each event transaction yields exactly one result transaction. An event is
// evaluated combinationally against the phase, block number, size and retry
// registers, and its result lands in an output register; one event can be
// taken every cycle, and a new event is taken while a result waits as long
// as that result leaves in the same cycle. The user must write registers over the
// apb port only while no event is in flight; the block does not enforce this.
module tftp_sender_retry_engine #(
  parameter int unsigned MAX_BLOCK_BYTES   = tftpsr_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = tftpsr_pkg::BLOCK_NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tftpsr_pkg::MODE_W-1:0]       in_mode,
  input  logic [tftpsr_pkg::SIZE_W-1:0]       in_payload_size,
  input  logic [tftpsr_pkg::ACK_W-1:0]        in_ack_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tftpsr_pkg::ACTION_W-1:0]     out_action,
  output logic [tftpsr_pkg::BLK_OUT_W-1:0]    out_block_number,
  output logic [tftpsr_pkg::SIZE_W-1:0]       out_block_size,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tftpsr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tftpsr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tftpsr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import tftpsr_pkg::*;

  localparam int unsigned BN = BLOCK_NUMBER_BITS;
  localparam int unsigned CW = (BN > ACK_W) ? BN : ACK_W;
  localparam int unsigned LW = 17;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_BLOCK_BYTES);

  cfg_t cfg;

  phase_t             phase_r, phase_nxt;
  logic [BN-1:0]      block_r, block_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [RETRY_W-1:0] retries_r, retries_nxt;
  logic               resend_r, resend_nxt;

  logic                out_valid_r;
  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [BN-1:0]       block_out_r;
  logic [SIZE_W-1:0]   size_out_r;

  logic                accept;
  logic [SIZE_W-1:0]   full_lo;
  logic [SIZE_W-1:0]   full_eff;
  logic [BN-1:0]       prev_blk;
  logic                dup_ack;
  logic [RETRY_W-1:0]  retries_dec;
  logic [CW-1:0]       block_ext;

  tftpsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // full block size clamped to 1..MAX_BLOCK_BYTES
  assign full_lo  = (cfg.full_block_size == '0) ? SIZE_W'(1) : cfg.full_block_size;
  assign full_eff = (LW'(full_lo) > MAX_L) ? MAX_L[SIZE_W-1:0] : full_lo;

  assign prev_blk    = block_r - BN'(1);
  assign dup_ack     = (CW'(in_ack_block) == CW'(prev_blk));
  assign retries_dec = (retries_r != '0) ? retries_r - RETRY_W'(1) : '0;

  always_comb begin
    phase_nxt   = phase_r;
    block_nxt   = block_r;
    size_nxt    = size_r;
    retries_nxt = retries_r;
    resend_nxt  = resend_r;
    action_nxt  = ACT_WAIT;
    case (in_mode)
      MODE_START: begin
        if (phase_r == PH_IDLE) begin
          block_nxt  = '0;
          resend_nxt = 1'b1;
          phase_nxt  = PH_FETCH;
          action_nxt = ACT_FETCH;
        end
      end
      MODE_READY: begin
        if (phase_r == PH_FETCH) begin
          size_nxt    = (in_payload_size > full_eff) ? full_eff : in_payload_size;
          block_nxt   = block_r + BN'(1);
          retries_nxt = cfg.retry_limit;
          if (cfg.retry_limit == '0) begin
            phase_nxt  = PH_IDLE;
            action_nxt = ACT_ABORT_RETRY;
          end else begin
            phase_nxt  = PH_WAIT;
            action_nxt = resend_r ? ACT_SEND : ACT_WAIT;
          end
        end
      end
      MODE_ACK: begin
        if (phase_r == PH_WAIT) begin
          if (dup_ack) begin
            resend_nxt  = 1'b0;
            retries_nxt = retries_dec;
            if (retries_dec == '0) begin
              phase_nxt  = PH_IDLE;
              action_nxt = ACT_ABORT_RETRY;
            end
          end else begin
            resend_nxt = 1'b1;
            if (size_r == full_eff) begin
              phase_nxt  = PH_FETCH;
              action_nxt = ACT_FETCH;
            end else begin
              phase_nxt  = PH_IDLE;
              action_nxt = ACT_DONE;
            end
          end
        end
      end
      MODE_TIMEOUT: begin
        if (phase_r == PH_WAIT) begin
          retries_nxt = retries_dec;
          if (retries_dec == '0) begin
            phase_nxt  = PH_IDLE;
            action_nxt = ACT_ABORT_RETRY;
          end else begin
            action_nxt = resend_r ? ACT_SEND : ACT_WAIT;
          end
        end
      end
      MODE_FAIL: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt  = PH_IDLE;
          action_nxt = ACT_ABORT_FAIL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      block_r     <= '0;
      size_r      <= '0;
      retries_r   <= '0;
      resend_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        block_r     <= block_nxt;
        size_r      <= size_nxt;
        retries_r   <= retries_nxt;
        resend_r    <= resend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r    <= action_nxt;
      block_out_r <= block_nxt;
      size_out_r  <= size_nxt;
    end
  end

  assign block_ext        = CW'(block_out_r);
  assign out_valid        = out_valid_r;
  assign out_action       = action_r;
  assign out_block_number = block_ext[BLK_OUT_W-1:0];
  assign out_block_size   = size_out_r;

endmodule
